// ===== hdl/grid_bucket_best_corner_macros.svh =====
// ----------------------------------------------------------------------------
// grid_bucket_best_corner assertion macros
// Shared property wrappers for the checker of the corner grid.
// ----------------------------------------------------------------------------
`ifndef GRID_BUCKET_BEST_CORNER_MACROS_SVH
`define GRID_BUCKET_BEST_CORNER_MACROS_SVH

// same-cycle implication
`define GBBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbbc_pkg
// Types, codes and widths shared by the corner grid modules.
// ----------------------------------------------------------------------------
package gbbc_pkg;

   localparam int MAX_CELLS_DEF  = 1024;
   localparam int NUM_LEVELS_DEF = 8;

   localparam int COORD_W    = 12;
   localparam int LEVEL_W    = 3;
   localparam int SCORE_W    = 24;
   localparam int READ_W     = 10;
   localparam int SIZE_W     = 8;
   localparam int COLS_W     = 11;
   localparam int REQ_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int ENTRY_W    = 2 * COORD_W + LEVEL_W + SCORE_W;

   localparam logic [REQ_W-1:0] REQ_MARK  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_OFFER = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_THRESHOLD = 2'd2;

   typedef enum logic [1:0] {
      OP_MARK,
      OP_OFFER,
      OP_READ,
      OP_READ_NONE
   } gbbc_op_type;

   typedef struct packed {
      gbbc_op_type          op;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [LEVEL_W-1:0]   level;
      logic [SCORE_W-1:0]   score;
   } gbbc_cmd_type;

   typedef struct packed {
      logic push;
      logic full;
   } gbbc_qctl_type;

endpackage

// ===== hdl/gbbc_queue.sv =====
// ----------------------------------------------------------------------------
// gbbc_queue
// Two-entry queue between the classifying front and the cell table.
// ----------------------------------------------------------------------------
module gbbc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end
endmodule

// ===== hdl/gbbc_front.sv =====
// ----------------------------------------------------------------------------
// gbbc_front
// Takes items, scales offers to level 0, finds the cell of a mark or offer by serial
// division and queues the classified command; out-of-range marks and offers are dropped here.
// ----------------------------------------------------------------------------
module gbbc_front #(
   parameter int MAX_CELLS  = gbbc_pkg::MAX_CELLS_DEF,
   parameter int NUM_LEVELS = gbbc_pkg::NUM_LEVELS_DEF,
   parameter int IDX_W      = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [gbbc_pkg::REQ_W-1:0]    req_type,
   input  logic [gbbc_pkg::COORD_W-1:0]  req_pos_x,
   input  logic [gbbc_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [gbbc_pkg::LEVEL_W-1:0]  req_pyr_level,
   input  logic [gbbc_pkg::SCORE_W-1:0]  req_corner_score,
   input  logic [gbbc_pkg::READ_W-1:0]   req_read_cell,
   input  logic [gbbc_pkg::SIZE_W-1:0]   cell_width,
   input  logic [gbbc_pkg::COLS_W-1:0]   grid_columns,
   output logic                          front_busy,
   output gbbc_pkg::gbbc_qctl_type       qctl_push,
   input  logic                          q_full,
   output gbbc_pkg::gbbc_cmd_type        cmd,
   output logic [IDX_W-1:0]              cmd_idx
);
   import gbbc_pkg::*;

   typedef enum logic [2:0] {F_IDLE, F_DIV, F_MUL, F_IDX, F_PUSH} front_state_type;

   front_state_type       state_ff, state_in;
   gbbc_cmd_type          cmd_ff, cmd_in;
   logic [COORD_W-1:0]    xq_ff, xq_in, yq_ff, yq_in;
   logic [SIZE_W:0]       xr_ff, xr_in, yr_ff, yr_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [22:0]           prod_ff, prod_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;

   logic [19:0]           sx_wide, sy_wide;
   logic                  lvl_bad, scale_bad;
   logic [SIZE_W:0]       xt, yt, div_ext;
   logic                  xge, yge;
   logic [23:0]           kval;
   logic                  col_ok, k_ok, rc_ok;

   assign front_busy     = (state_ff != F_IDLE);
   assign qctl_push.push = (state_ff == F_PUSH) && !q_full;
   assign qctl_push.full = q_full;
   assign cmd            = cmd_ff;
   assign cmd_idx        = idx_ff;

   always_comb begin
      sx_wide   = {8'd0, req_pos_x} << req_pyr_level;
      sy_wide   = {8'd0, req_pos_y} << req_pyr_level;
      lvl_bad   = ({1'b0, req_pyr_level} >= 4'(NUM_LEVELS));
      scale_bad = (|sx_wide[19:12]) || (|sy_wide[19:12]);
      rc_ok     = ({7'd0, req_read_cell} < 17'(MAX_CELLS));
      div_ext   = {1'b0, cell_width};
      xt        = {xr_ff[SIZE_W-1:0], xq_ff[COORD_W-1]};
      yt        = {yr_ff[SIZE_W-1:0], yq_ff[COORD_W-1]};
      xge       = (xt >= div_ext);
      yge       = (yt >= div_ext);
      kval      = {1'b0, prod_ff} + {12'd0, xq_ff};
      col_ok    = ({1'b0, grid_columns} > xq_ff);
      k_ok      = (kval < 24'(MAX_CELLS));

      state_in = state_ff;
      cmd_in   = cmd_ff;
      xq_in    = xq_ff;
      yq_in    = yq_ff;
      xr_in    = xr_ff;
      yr_in    = yr_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      idx_in   = idx_ff;

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               cmd_in.level = req_pyr_level;
               cmd_in.score = req_corner_score;
               xr_in        = '0;
               yr_in        = '0;
               cnt_in       = 4'd0;
               priority if (req_type == REQ_MARK) begin
                  cmd_in.op = OP_MARK;
                  cmd_in.x  = req_pos_x;
                  cmd_in.y  = req_pos_y;
                  xq_in     = req_pos_x;
                  yq_in     = req_pos_y;
                  if (cell_width != '0) state_in = F_DIV;
               end else if (req_type == REQ_OFFER) begin
                  cmd_in.op = OP_OFFER;
                  cmd_in.x  = sx_wide[COORD_W-1:0];
                  cmd_in.y  = sy_wide[COORD_W-1:0];
                  xq_in     = sx_wide[COORD_W-1:0];
                  yq_in     = sy_wide[COORD_W-1:0];
                  if (cell_width != '0 && !lvl_bad && !scale_bad) state_in = F_DIV;
               end else if (req_type == REQ_READ) begin
                  cmd_in.op = rc_ok ? OP_READ : OP_READ_NONE;
                  idx_in    = IDX_W'(req_read_cell);
                  state_in  = F_PUSH;
               end else begin
                  state_in = F_IDLE; // unknown request: drop
               end
            end
         end
         F_DIV: begin
            xr_in  = xge ? (xt - div_ext) : xt;
            yr_in  = yge ? (yt - div_ext) : yt;
            xq_in  = {xq_ff[COORD_W-2:0], xge};
            yq_in  = {yq_ff[COORD_W-2:0], yge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(COORD_W - 1)) state_in = F_MUL;
         end
         F_MUL: begin
            prod_in  = {11'd0, yq_ff} * {12'd0, grid_columns};
            state_in = F_IDX;
         end
         F_IDX: begin
            idx_in   = kval[IDX_W-1:0];
            state_in = (col_ok && k_ok) ? F_PUSH : F_IDLE;
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      xq_ff   <= xq_in;
      yq_ff   <= yq_in;
      xr_ff   <= xr_in;
      yr_ff   <= yr_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      idx_ff  <= idx_in;
   end
endmodule

// ===== hdl/gbbc_back.sv =====
// ----------------------------------------------------------------------------
// gbbc_back
// Owns the cell table: read-modify-write of occupancy, valid and winner,
// read-out of results, and the clearing pass after reset.
// ----------------------------------------------------------------------------
module gbbc_back #(
   parameter int MAX_CELLS = gbbc_pkg::MAX_CELLS_DEF,
   parameter int IDX_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  gbbc_pkg::gbbc_cmd_type        cmd,
   input  logic [IDX_W-1:0]              cmd_idx,
   input  logic [gbbc_pkg::SCORE_W-1:0]  score_threshold,
   output logic                          clearing,
   output logic                          rsp_valid,
   output logic                          rsp_corner_found,
   output logic [gbbc_pkg::COORD_W-1:0]  rsp_corner_x,
   output logic [gbbc_pkg::COORD_W-1:0]  rsp_corner_y,
   output logic [gbbc_pkg::LEVEL_W-1:0]  rsp_corner_level,
   output logic [gbbc_pkg::SCORE_W-1:0]  rsp_winner_score
);
   import gbbc_pkg::*;

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_EXEC} back_state_type;

   // flag bit 1: occupied, bit 0: valid
   logic [1:0]          flag_mem  [MAX_CELLS];
   logic [ENTRY_W-1:0]  entry_mem [MAX_CELLS];

   back_state_type      state_ff;
   logic [IDX_W-1:0]    clr_ff;
   gbbc_cmd_type        cur_ff;
   logic [IDX_W-1:0]    cur_idx_ff;
   logic [1:0]          flag_rd_ff;
   logic [ENTRY_W-1:0]  entry_rd_ff;
   logic                rsp_valid_ff, found_ff;
   logic [COORD_W-1:0]  x_ff, y_ff;
   logic [LEVEL_W-1:0]  lvl_ff;
   logic [SCORE_W-1:0]  score_ff;

   logic                occ, val, keep, found;
   logic [SCORE_W-1:0]  stored_score;
   logic                flag_we, entry_we;
   logic [IDX_W-1:0]    flag_wa;
   logic [1:0]          flag_wd;

   assign q_pop    = (state_ff == B_IDLE) && !q_empty;
   assign clearing = (state_ff == B_CLEAR);

   always_comb begin
      occ          = flag_rd_ff[1];
      val          = flag_rd_ff[0];
      stored_score = entry_rd_ff[SCORE_W-1:0];
      keep         = !occ && (cur_ff.score > score_threshold)
                     && (!val || (cur_ff.score > stored_score));
      found        = val && (stored_score > score_threshold);
      flag_we      = 1'b0;
      entry_we     = 1'b0;
      flag_wd      = 2'b00;
      flag_wa      = clearing ? clr_ff : cur_idx_ff;
      if (clearing) begin
         flag_we = 1'b1;
      end else if (state_ff == B_EXEC) begin
         unique case (cur_ff.op)
            OP_MARK: begin
               flag_we = 1'b1;
               flag_wd = {1'b1, val};
            end
            OP_OFFER: begin
               flag_we  = keep;
               entry_we = keep;
               flag_wd  = 2'b01;
            end
            OP_READ: begin
               flag_we = 1'b1;
            end
            OP_READ_NONE: begin
               flag_we = 1'b0;
            end
            default: flag_we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_wa] <= flag_wd;
      if (entry_we) begin
         entry_mem[cur_idx_ff] <= {cur_ff.x, cur_ff.y, cur_ff.level, cur_ff.score};
      end
      flag_rd_ff  <= flag_mem[cmd_idx];
      entry_rd_ff <= entry_mem[cmd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IDX_W'(MAX_CELLS - 1)) state_ff <= B_IDLE;
            end
            B_IDLE: begin
               if (!q_empty) state_ff <= B_EXEC;
            end
            B_EXEC: begin
               state_ff <= B_IDLE;
               if (cur_ff.op == OP_READ || cur_ff.op == OP_READ_NONE) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
      if (q_pop) begin
         cur_ff     <= cmd;
         cur_idx_ff <= cmd_idx;
      end
      if (state_ff == B_EXEC) begin
         if (cur_ff.op == OP_READ && found) begin
            found_ff <= 1'b1;
            x_ff     <= entry_rd_ff[ENTRY_W-1 -: COORD_W];
            y_ff     <= entry_rd_ff[ENTRY_W-COORD_W-1 -: COORD_W];
            lvl_ff   <= entry_rd_ff[SCORE_W+LEVEL_W-1 -: LEVEL_W];
            score_ff <= stored_score;
         end else begin
            found_ff <= 1'b0;
            x_ff     <= '0;
            y_ff     <= '0;
            lvl_ff   <= '0;
            score_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_corner_found = found_ff;
   assign rsp_corner_x     = x_ff;
   assign rsp_corner_y     = y_ff;
   assign rsp_corner_level = lvl_ff;
   assign rsp_winner_score = score_ff;
endmodule

// ===== hdl/grid_bucket_best_corner.sv =====
// ----------------------------------------------------------------------------
// grid_bucket_best_corner
// Keeps the best corner per grid cell: mark, offer and read-and-clear items.
// ----------------------------------------------------------------------------
//  channel  ports                       handshake
//  request  start/busy, req_*           taken when start && !busy
//  result   rsp_valid, rsp_*            one-cycle strobe, no back-pressure
//  config   csr_valid/csr_ready, csr_*  written when csr_valid && csr_ready
//
//  A mark or offer passes through the front as a 12-step serial divide of both
//  coordinates by the cell width, a multiply, an index check and a queue push; a
//  read goes straight to the queue push. The table side handles each item as a
//  registered memory read, then a write, before it takes the next. A two-entry
//  queue lets the front take the next item while the table works. After reset
//  the table clears every cell with busy high.
// ----------------------------------------------------------------------------
module grid_bucket_best_corner #(
   parameter int MAX_CELLS  = gbbc_pkg::MAX_CELLS_DEF,
   parameter int NUM_LEVELS = gbbc_pkg::NUM_LEVELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [gbbc_pkg::REQ_W-1:0]       req_type,
   input  logic [gbbc_pkg::COORD_W-1:0]     req_pos_x,
   input  logic [gbbc_pkg::COORD_W-1:0]     req_pos_y,
   input  logic [gbbc_pkg::LEVEL_W-1:0]     req_pyr_level,
   input  logic [gbbc_pkg::SCORE_W-1:0]     req_corner_score,
   input  logic [gbbc_pkg::READ_W-1:0]      req_read_cell,
   output logic                             rsp_valid,
   output logic                             rsp_corner_found,
   output logic [gbbc_pkg::COORD_W-1:0]     rsp_corner_x,
   output logic [gbbc_pkg::COORD_W-1:0]     rsp_corner_y,
   output logic [gbbc_pkg::LEVEL_W-1:0]     rsp_corner_level,
   output logic [gbbc_pkg::SCORE_W-1:0]     rsp_winner_score,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gbbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gbbc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gbbc_pkg::*;

   localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int QW    = $bits(gbbc_cmd_type) + IDX_W;

   logic [SIZE_W-1:0]   cell_width_ff;
   logic [COLS_W-1:0]   grid_columns_ff;
   logic [SCORE_W-1:0]  threshold_ff;

   logic                front_busy, clearing, accept;
   gbbc_qctl_type       qctl;
   logic                q_full, q_empty, q_pop;
   gbbc_cmd_type        f_cmd, b_cmd;
   logic [IDX_W-1:0]    f_idx, b_idx;

   assign csr_ready = 1'b1;
   assign busy      = front_busy || clearing;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff   <= SIZE_W'(32);
         grid_columns_ff <= COLS_W'(20);
         threshold_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CELL_WIDTH:      cell_width_ff   <= csr_data[SIZE_W-1:0];
            CSR_GRID_COLUMNS:    grid_columns_ff <= csr_data[COLS_W-1:0];
            CSR_SCORE_THRESHOLD: threshold_ff    <= csr_data;
            default:             threshold_ff    <= threshold_ff;
         endcase
      end
   end

   gbbc_front #(
      .MAX_CELLS  (MAX_CELLS),
      .NUM_LEVELS (NUM_LEVELS),
      .IDX_W      (IDX_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_type         (req_type),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pyr_level    (req_pyr_level),
      .req_corner_score (req_corner_score),
      .req_read_cell    (req_read_cell),
      .cell_width       (cell_width_ff),
      .grid_columns     (grid_columns_ff),
      .front_busy       (front_busy),
      .qctl_push        (qctl),
      .q_full           (q_full),
      .cmd              (f_cmd),
      .cmd_idx          (f_idx)
   );

   gbbc_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (qctl.push),
      .din   ({f_cmd, f_idx}),
      .pop   (q_pop),
      .dout  ({b_cmd, b_idx}),
      .full  (q_full),
      .empty (q_empty)
   );

   gbbc_back #(
      .MAX_CELLS (MAX_CELLS),
      .IDX_W     (IDX_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .cmd              (b_cmd),
      .cmd_idx          (b_idx),
      .score_threshold  (threshold_ff),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_corner_found (rsp_corner_found),
      .rsp_corner_x     (rsp_corner_x),
      .rsp_corner_y     (rsp_corner_y),
      .rsp_corner_level (rsp_corner_level),
      .rsp_winner_score (rsp_winner_score)
   );
endmodule

// ===== hdl/gbbc_checker.sv =====
// ----------------------------------------------------------------------------
// gbbc_checker
// Port-level checks of the corner grid, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_bucket_best_corner_macros.svh"

module gbbc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [gbbc_pkg::REQ_W-1:0]      req_type,
   input logic                            rsp_valid,
   input logic                            rsp_corner_found,
   input logic [gbbc_pkg::COORD_W-1:0]    rsp_corner_x,
   input logic [gbbc_pkg::COORD_W-1:0]    rsp_corner_y,
   input logic [gbbc_pkg::LEVEL_W-1:0]    rsp_corner_level,
   input logic [gbbc_pkg::SCORE_W-1:0]    rsp_winner_score,
   input logic                            csr_ready
);
   import gbbc_pkg::*;

   // a read item keeps the block busy in the next cycle
   `GBBC_ASSERT_NEXT(a_busy_after_read, clock, reset,
      start && !busy && req_type == REQ_READ, busy, "busy not raised after read item")
   // an empty read reports all zero
   `GBBC_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && !rsp_corner_found,
      rsp_corner_x == '0 && rsp_corner_y == '0 && rsp_corner_level == '0
      && rsp_winner_score == '0, "empty read not zero")
   // a found winner beats a threshold of at least zero
   `GBBC_ASSERT_NOW(a_found_score, clock, reset, rsp_valid && rsp_corner_found,
      rsp_winner_score != '0, "found winner with zero score")
   // the clearing pass holds the block busy right after reset
   `GBBC_ASSERT_NEXT(a_clear_busy, clock, 1'b0, reset, busy && !rsp_valid,
      "not busy after reset")
   `GBBC_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_ready, "csr port not ready")
endmodule

bind grid_bucket_best_corner gbbc_checker u_gbbc_checker (.*);
